/* rtl/core/gb3_pkg.sv */
// Shared types and constants for the 3x3 Gaussian blur stream filter.
package gb3_pkg;

  localparam int unsigned PIX_W  = 8;   // gray level
  localparam int unsigned CFG_W  = 12;  // width/height registers
  localparam int unsigned ROW_W  = 13;  // input row counter, runs to height + 1 in flush
  localparam int unsigned OROW_W = 12;  // output row counter, below height
  localparam int unsigned SUM_W  = 12;  // 16 * 255 fits

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Control and data of one item between the counter stage and the window stage.
  typedef struct packed {
    logic             emit;      // item produces an output pixel
    logic             interior;  // output pixel gets the full kernel
    logic             last;      // output pixel closes the frame
    logic             fwd;       // row store read collides with the write in flight
    logic [PIX_W-1:0] pixel;     // new bottom-row sample (zero during flush)
  } item_t;

endpackage

/* rtl/core/gaussian_blur_3x3.sv */
// Top level of the streaming 3x3 Gaussian blur (1-2-1 by 1-2-1, /16) on gray frames.
//
//  Channel  Dir  Payload                                   Handshake
//  s_axis   in   tdata[7:0] pixel_gray, tuser kind         tvalid/tready
//  m_axis   out  tdata[7:0] gray_out, tlast frame_last     tvalid/tready
//  cfg      in   cfg_idx_i register, cfg_wdata_i value     cfg_we_i, no wait
//
//  One item per cycle sustained while m_axis is not stalled; the item that causes a
//  result passes the row store read, then the window/sum into the output register.
//  Each output is the pixel one line plus one pixel earlier; width + 1 flush
//  items after the frame's last pixel drain it.
//  Reset needs no clearing pass; row store contents are unused until written.
//  s_axis_tready drops only while a result waits in the output register and
//  the window stage holds the next one.
module gaussian_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gb3_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] pixel_gray
  input  logic                      s_axis_tuser,   // [0] kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] gray_out
  output logic                      m_axis_tlast
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = gb3_pkg::PIX_W;

  logic           s1_ready;
  logic           ram_re, ram_we;
  logic [CW-1:0]  ram_raddr, ram_waddr;
  logic [PW-1:0]  rd_upper, rd_middle, wr_upper, wr_middle;
  logic           item_valid;
  gb3_pkg::item_t item;

  gb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_kind_i    (s_axis_tuser),
    .in_pixel_i   (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .s1_ready_i   (s1_ready),
    .wr_en_i      (ram_we),
    .wr_addr_i    (ram_waddr),
    .rd_en_o      (ram_re),
    .rd_addr_o    (ram_raddr),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_upper),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_upper)
  );

  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_middle),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_middle)
  );

  gb3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .addr_i       (ram_raddr),
    .s1_ready_o   (s1_ready),
    .rd_upper_i   (rd_upper),
    .rd_middle_i  (rd_middle),
    .wr_en_o      (ram_we),
    .wr_addr_o    (ram_waddr),
    .wr_upper_o   (wr_upper),
    .wr_middle_o  (wr_middle),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_gray_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // Input stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // The item after a frame's last output starts a new frame and cannot emit.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && item.emit && item.last) |=> !(item_valid && item.emit))
    else $error("emission right after frame end");

  // Row stores are read only for accepted items.
  a_read_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (s_axis_tvalid && s_axis_tready))
    else $error("row store read without an input transfer");

endmodule

/* rtl/core/gb3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gb3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gb3_ctrl.sv */
// Configuration registers, frame counters and row store read issue.
module gb3_ctrl #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gb3_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_kind_i,
  input  logic [gb3_pkg::PIX_W-1:0]   in_pixel_i,
  output logic                        in_ready_o,
  input  logic                        s1_ready_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  output logic                        rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output logic                        item_valid_o,
  output gb3_pkg::item_t              item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned RW = gb3_pkg::ROW_W;
  localparam int unsigned OW = gb3_pkg::OROW_W;

  logic [gb3_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [CW-1:0]             ocol_q, ocol_d;
  logic [OW-1:0]             orow_q, orow_d;

  logic [WW-1:0]             eff_w;
  logic [gb3_pkg::CFG_W-1:0] eff_h;
  logic [RW-1:0]             eff_h_ext;
  logic                      active, ignored, take, accept;
  logic                      emit, interior, last;
  logic [WW-1:0]             col_inc, ocol_inc;
  logic                      col_wrap, ocol_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gb3_pkg::WIDTH_RST;
      height_q <= gb3_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (gb3_pkg::cfg_idx_e'(cfg_idx_i))
        gb3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        gb3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Zero means one; width saturates at the store depth.
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h     = (height_q == '0) ? gb3_pkg::CFG_W'(1) : height_q;
    eff_h_ext = RW'(eff_h);
  end

  assign in_ready_o = s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign active     = row_q < eff_h_ext;
  // A flush before the frame's last pixel does nothing at all.
  assign ignored    = (gb3_pkg::kind_e'(in_kind_i) == gb3_pkg::KIND_FLUSH) && active;
  assign take       = accept && !ignored;

  // Output starts once one line plus one pixel has gone in: row*w + col >= w + 1.
  assign emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0)) ||
                ((row_q == '0) && (WW'(col_q) > eff_w));

  assign interior = (ocol_q != '0) && ((WW'(ocol_q) + WW'(1)) < eff_w) &&
                    (orow_q != '0) && ((RW'(orow_q) + RW'(1)) < eff_h_ext);
  assign last     = ((WW'(ocol_q) + WW'(1)) >= eff_w) &&
                    ((RW'(orow_q) + RW'(1)) >= eff_h_ext);

  assign col_inc   = WW'(col_q) + WW'(1);
  assign col_wrap  = col_inc >= eff_w;
  assign ocol_inc  = WW'(ocol_q) + WW'(1);
  assign ocol_wrap = ocol_inc >= eff_w;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (take) begin
      if (emit && last) begin
        col_d  = '0;
        row_d  = '0;
        ocol_d = '0;
        orow_d = '0;
      end else begin
        col_d = col_wrap ? '0 : col_inc[CW-1:0];
        row_d = col_wrap ? row_q + RW'(1) : row_q;
        if (emit) begin
          ocol_d = ocol_wrap ? '0 : ocol_inc[CW-1:0];
          orow_d = ocol_wrap ? orow_q + OW'(1) : orow_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  assign rd_en_o   = take;
  assign rd_addr_o = col_q;

  assign item_valid_o    = take;
  assign item_o.emit     = emit;
  assign item_o.interior = interior;
  assign item_o.last     = last;
  // Same column as the write-back in flight (width of one, or a new frame's first item): take the written values.
  assign item_o.fwd      = wr_en_i && (wr_addr_i == col_q);
  assign item_o.pixel    = active ? in_pixel_i : '0;

endmodule

/* rtl/core/gb3_window.sv */
// Row store write-back, 3x3 window, kernel sum and output register.
module gb3_window #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  gb3_pkg::item_t               item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  output logic                         s1_ready_o,
  input  logic [gb3_pkg::PIX_W-1:0]    rd_upper_i,
  input  logic [gb3_pkg::PIX_W-1:0]    rd_middle_i,
  output logic                         wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr_o,
  output logic [gb3_pkg::PIX_W-1:0]    wr_upper_o,
  output logic [gb3_pkg::PIX_W-1:0]    wr_middle_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gb3_pkg::PIX_W-1:0]    out_gray_o,
  output logic                         out_last_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = gb3_pkg::PIX_W;
  localparam int unsigned SW = gb3_pkg::SUM_W;

  logic                 s1_valid_q;
  gb3_pkg::item_t       s1_item_q;
  logic [CW-1:0]        s1_addr_q;
  logic [PW-1:0]        fwd_upper_q, fwd_middle_q;
  logic [PW-1:0]        win_q [6];
  logic                 out_valid_q, out_last_q;
  logic [PW-1:0]        out_gray_q;

  logic                 s1_go;
  logic [PW-1:0]        n0, n1, n2;
  logic [SW-1:0]        sum;
  logic [PW-1:0]        center;

  // Stage holds only when it has a result and the output slot stays full.
  assign s1_go      = s1_valid_q && (!s1_item_q.emit || !out_valid_q || out_ready_i);
  assign s1_ready_o = !s1_valid_q || s1_go;

  assign n0 = s1_item_q.fwd ? fwd_upper_q  : rd_upper_i;
  assign n1 = s1_item_q.fwd ? fwd_middle_q : rd_middle_i;
  assign n2 = s1_item_q.pixel;

  assign wr_en_o     = s1_go;
  assign wr_addr_o   = s1_addr_q;
  assign wr_upper_o  = n1;
  assign wr_middle_o = n2;

  assign sum = SW'(win_q[0]) + (SW'(win_q[1]) << 1) + SW'(win_q[2]) +
               (SW'(win_q[3]) << 1) + (SW'(win_q[4]) << 2) + (SW'(win_q[5]) << 1) +
               SW'(n0) + (SW'(n1) << 1) + SW'(n2);
  assign center = s1_item_q.interior ? sum[SW-1:4] : win_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s1_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && item_valid_i) begin
      s1_item_q    <= item_i;
      s1_addr_q    <= addr_i;
      fwd_upper_q  <= n1;
      fwd_middle_q <= n2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_go) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= n0;
      win_q[4] <= n1;
      win_q[5] <= n2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_item_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_item_q.emit) begin
      out_gray_q <= center;
      out_last_q <= s1_item_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_gray_o  = out_gray_q;
  assign out_last_o  = out_last_q;

endmodule

/* tb/gaussian_blur_3x3_tb.sv */
// Self-checking testbench for the 3x3 Gaussian blur stream filter.
module gaussian_blur_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int unsigned STORE_DEPTH    = 2048;
  localparam int unsigned SETTLE_CYCLES  = 8;     // pipeline is two deep, keep some margin
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             last;
  } blur_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_idx_i     = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [7:0] pixel_gray
  logic             s_axis_tuser  = KIND_PIXEL;  // [0] kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;   // [7:0] gray_out
  logic             m_axis_tlast;

  gaussian_blur_3x3 #(
    .MAX_WIDTH(STORE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the filter state
  logic [CFG_W-1:0] width_reg  = WIDTH_RST;
  logic [CFG_W-1:0] height_reg = HEIGHT_RST;
  logic [PIX_W-1:0] upper_rows  [STORE_DEPTH] = '{default: '0};
  logic [PIX_W-1:0] middle_rows [STORE_DEPTH] = '{default: '0};
  logic [PIX_W-1:0] window [6] = '{default: '0};
  int unsigned      in_col  = 0;
  int unsigned      in_row  = 0;
  int unsigned      out_pos = 0;

  blur_result_t     blurred_pixels[$];

  int unsigned      error_count = 0;
  int unsigned      body_items  = 0;
  int unsigned      burst_left  = 0;
  int unsigned      idle_cycles = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Advances the shadow state by one accepted item; queues the output pixel if any.
  function automatic void blur_predict(input kind_e k, input logic [PIX_W-1:0] pix);
    int unsigned      w, h, idx, orow, ocol, sum;
    logic [PIX_W-1:0] data, n0, n1, n2, center;
    bit               emit;
    blur_result_t     res;
    w = eff_width();
    h = eff_height();
    if (k == KIND_FLUSH && in_row < h) return;  // flush before the frame is complete
    data = (in_row < h) ? pix : '0;             // late pixel drains like a flush
    idx  = (in_col < STORE_DEPTH) ? in_col : STORE_DEPTH - 1;
    n0 = upper_rows[idx];
    n1 = middle_rows[idx];
    n2 = data;
    upper_rows[idx]  = n1;
    middle_rows[idx] = n2;
    emit   = (in_row * w + in_col) >= w + 1;
    center = window[4];
    if (emit) begin
      orow = out_pos / w;
      ocol = out_pos % w;
      if (ocol >= 1 && ocol + 1 < w && orow >= 1 && orow + 1 < h) begin
        sum = window[0] + 2 * window[1] + window[2]
            + 2 * window[3] + 4 * window[4] + 2 * window[5]
            + n0 + 2 * n1 + n2;
        center = sum >> 4;
      end
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = n0;
    window[4] = n1;
    window[5] = n2;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < 'hFFFF) in_row++;
    end
    if (!emit) return;
    res.gray = center;
    if (out_pos + 1 >= w * h) begin
      res.last = 1'b1;
      in_col   = 0;
      in_row   = 0;
      out_pos  = 0;
    end else begin
      res.last = 1'b0;
      out_pos++;
    end
    blurred_pixels.push_back(res);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Sends one item in bursts separated by random gaps.
  task automatic send_item(input kind_e k, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    blur_predict(k, pix);
  endtask

  // Idles the sender and waits until every expected pixel has left the block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (blurred_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Rest of a frame from pixel 'already' on, then the drain; noise_pct adds
  // ignored flush ticks, late pixels during the drain and trailing ticks.
  task automatic send_frame(input int unsigned already, input int unsigned noise_pct);
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    for (n = already; n < w * h; n++) begin
      if ($urandom_range(99) < noise_pct) send_item(KIND_FLUSH, $urandom_range(255));
      send_item(KIND_PIXEL, rand_pixel());
    end
    for (n = 0; n <= w; n++)
      send_item(($urandom_range(99) < noise_pct) ? KIND_PIXEL : KIND_FLUSH, rand_pixel());
    if (noise_pct != 0)
      repeat ($urandom_range(2)) send_item(KIND_FLUSH, $urandom_range(255));
    body_items += w * h - already + w + 1;
  endtask

  task automatic test_directed_frame();
    int unsigned i;
    settle();
    set_size(4, 4);
    for (i = 0; i < 16; i++) begin
      if (i == 0 || i == 9) send_item(KIND_FLUSH, 8'hFF);  // early flush, dropped
      send_item(KIND_PIXEL, (i % 4 == 3) ? 8'h00 : 8'hFF);
    end
    for (i = 0; i < 5; i++) send_item(i[0] ? KIND_PIXEL : KIND_FLUSH, 8'hA5);
  endtask

  task automatic test_size_extremes();
    int unsigned sizes [4][2];
    int unsigned i;
    // zero width/height fall back to 1, 4095 width saturates to the store depth
    sizes = '{'{0, 0}, '{3, 3}, '{4095, 1}, '{1, 4095}};
    for (i = 0; i < 4; i++) begin
      settle();
      set_size(sizes[i][0], sizes[i][1]);
      send_frame(0, 5);
    end
  endtask

  task automatic test_config_in_first_row();
    settle();
    set_size(6, 4);
    repeat (3) send_item(KIND_PIXEL, rand_pixel());
    settle();
    // counters are kept; the stores still get a full first row under the new width
    write_reg(CFG_IMAGE_HEIGHT, 5);
    write_reg(CFG_IMAGE_WIDTH, 8);
    send_frame(3, 0);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, noise;
    body_items = 0;
    while (body_items < RANDOM_ITEMS) begin
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(24, 64);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 8);
      end
      noise = $urandom_range(1) ? 0 : $urandom_range(2, 15);
      settle();
      set_size(w, h);
      send_frame(0, noise);
    end
  endtask

  // Output side: checks each transfer and stalls on its own pattern.
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;
  int unsigned rx_hold  = 0;

  always @(posedge clk_i) begin
    blur_result_t exp_res;
    logic         ready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blurred_pixels.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: gray %0d last %0b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        exp_res = blurred_pixels.pop_front();
        if (m_axis_tdata !== exp_res.gray || m_axis_tlast !== exp_res.last) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: expected gray %0d last %0b, got gray %0d last %0b",
                     exp_res.gray, exp_res.last, m_axis_tdata, m_axis_tlast);
          error_count++;
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(3);
    case (rx_mode)
      0: ready = 1'b1;
      1: ready = ($urandom_range(3) != 0);
      2: begin
        if (rx_hold != 0) begin
          rx_hold--;
          ready = 1'b0;
        end else begin
          ready = 1'b1;
          if ($urandom_range(7) == 0) rx_hold = $urandom_range(1, 12);
        end
      end
      default: ready = $urandom_range(1);
    endcase
    m_axis_tready <= ready;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frame();
    test_size_extremes();
    test_config_in_first_row();
    test_random_frames();
    settle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
